>>> hdl/csn_pkg.sv
// shared constants and types for the color sensor offset normalizer
`default_nettype none
package csn_pkg;
  localparam int SensorCount = 8;
  localparam int CalSamples  = 4;
  localparam int Channels    = 5;
  localparam int SensW       = 3;
  localparam int SumW        = 16 + $clog2(CalSamples + 1);
  localparam int CntW        = $clog2(CalSamples + 1);
  localparam int ShareScale  = 255;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_CAL     = 2'd1,
    ACT_MEASURE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  // classified item handed from front to back
  typedef struct packed {
    action_e     act;
    logic [2:0]  sensor;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] prox;
    logic [15:0] amb;
  } item_t;
endpackage
`default_nettype wire

>>> hdl/csn_front.sv
// front end: accepts transactions, drops unused ones, queues the rest
`default_nettype none
module csn_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire logic [1:0]    action_i,
  input  wire logic [2:0]    sensor_i,
  input  wire logic [15:0]   red_raw_i,
  input  wire logic [15:0]   green_raw_i,
  input  wire logic [15:0]   blue_raw_i,
  input  wire logic [15:0]   proximity_raw_i,
  input  wire logic [15:0]   ambient_raw_i,
  output csn_pkg::item_t     item_o,
  output logic               item_valid_o,
  input  wire logic          item_take_i
);
  import csn_pkg::*;

  item_t     fifo_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;
  logic      push, pop, keep;
  item_t     in_item;

  assign stall_o = (cnt_q == 2'd2);
  assign keep = (action_i != ACT_NONE) && ({1'b0, sensor_i} < 4'(SensorCount));
  assign push = valid_i && !stall_o && keep;
  assign pop  = item_take_i && item_valid_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o = fifo_q[rd_q];

  always_comb begin
    in_item.act    = action_e'(action_i);
    in_item.sensor = sensor_i;
    in_item.red    = red_raw_i;
    in_item.green  = green_raw_i;
    in_item.blue   = blue_raw_i;
    in_item.prox   = proximity_raw_i;
    in_item.amb    = ambient_raw_i;
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= in_item;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> hdl/csn_div.sv
// serial signed divider for share computation
`default_nettype none
module csn_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [25:0] num_i,
  input  wire logic signed [18:0] den_i,
  output logic                    done_o,
  output logic signed [25:0]      quo_o
);
  logic [25:0] q_q;
  logic [18:0] r_q;
  logic [18:0] d_q;
  logic        neg_q, busy_q;
  logic [4:0]  n_q;
  logic [19:0] trial;
  logic [18:0] rsh;

  assign rsh = {r_q[17:0], q_q[25]};
  assign trial = {1'b0, rsh} - {1'b0, d_q};
  assign quo_o = neg_q ? -$signed(q_q) : $signed(q_q);

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      n_q <= '0;
      neg_q <= 1'b0;
      q_q <= '0;
      r_q <= '0;
      d_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q <= 5'd26;
        neg_q <= num_i[25] ^ den_i[18];
        q_q <= num_i[25] ? 26'(-num_i) : num_i;
        d_q <= den_i[18] ? 19'(-den_i) : den_i;
        r_q <= '0;
      end else if (busy_q) begin
        if (!trial[19]) begin
          r_q <= trial[18:0];
          q_q <= {q_q[24:0], 1'b1};
        end else begin
          r_q <= rsh;
          q_q <= {q_q[24:0], 1'b0};
        end
        n_q <= n_q - 5'd1;
        if (n_q == 5'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/csn_back.sv
// back end: calibration state, offset correction and share normalization
`default_nettype none
module csn_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire csn_pkg::item_t item_i,
  input  wire logic          item_valid_i,
  output logic               item_take_o,
  output logic               valid_o,
  input  wire logic          stall_i,
  output logic [2:0]         sensor_out_o,
  output logic signed [16:0] red_corrected_o,
  output logic signed [16:0] green_corrected_o,
  output logic signed [16:0] blue_corrected_o,
  output logic signed [16:0] proximity_corrected_o,
  output logic signed [16:0] ambient_corrected_o,
  output logic [7:0]         red_share_o,
  output logic [7:0]         green_share_o,
  output logic [7:0]         blue_share_o,
  output logic               share_kept_o,
  output logic               share_clamped_o
);
  import csn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_OUT
  } state_e;

  // one register word per sensor, all channels side by side
  logic [Channels-1:0][SumW-1:0] sums_q [SensorCount];
  logic [Channels-1:0][15:0]     offs_q [SensorCount];
  logic [CntW-1:0]   cnts_q  [SensorCount];
  logic [7:0]        kept_q  [SensorCount][3];

  state_e            state_q;
  item_t             it_q;
  logic signed [16:0] corr_q [Channels];
  logic signed [18:0] tot_q;
  logic [1:0]        k_q;
  logic              clamp_q;
  logic [7:0]        sh_q [3];

  logic [15:0]       raw [Channels];
  logic              dstart, ddone;
  logic signed [25:0] num, quo;

  assign raw[0] = item_i.red;
  assign raw[1] = item_i.green;
  assign raw[2] = item_i.blue;
  assign raw[3] = item_i.prox;
  assign raw[4] = item_i.amb;

  assign item_take_o = (state_q == ST_IDLE) && item_valid_i;
  assign dstart = (state_q == ST_DIV_START);
  assign num = 26'(corr_q[3'(k_q)]) * 26'sd255;

  csn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (num),
    .den_i   (tot_q),
    .done_o  (ddone),
    .quo_o   (quo)
  );

  // calibration and kept-share state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SensorCount; s++) begin
        cnts_q[s] <= '0;
        for (int c = 0; c < Channels; c++) begin
          sums_q[s][c] <= '0;
          offs_q[s][c] <= '0;
        end
        for (int k = 0; k < 3; k++) kept_q[s][k] <= '0;
      end
    end else begin
      if (item_take_o && item_i.act == ACT_CLEAR) begin
        cnts_q[item_i.sensor] <= '0;
        for (int c = 0; c < Channels; c++) begin
          sums_q[item_i.sensor][c] <= '0;
          offs_q[item_i.sensor][c] <= '0;
        end
      end
      if (item_take_o && item_i.act == ACT_CAL) begin
        if (cnts_q[item_i.sensor] + CntW'(1) >= CntW'(CalSamples)) begin
          cnts_q[item_i.sensor] <= '0;
          for (int c = 0; c < Channels; c++) begin
            sums_q[item_i.sensor][c] <= '0;
            offs_q[item_i.sensor][c] <= 16'((sums_q[item_i.sensor][c] +
                                      SumW'(raw[c])) / CalSamples);
          end
        end else begin
          cnts_q[item_i.sensor] <= cnts_q[item_i.sensor] + CntW'(1);
          for (int c = 0; c < Channels; c++)
            sums_q[item_i.sensor][c] <= sums_q[item_i.sensor][c] + SumW'(raw[c]);
        end
      end
      if (state_q == ST_OUT && valid_o == 1'b0 && tot_q != '0) begin
        for (int k = 0; k < 3; k++) kept_q[it_q.sensor][k] <= sh_q[k];
      end
    end
  end

  // measurement sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_o <= 1'b0;
      k_q <= '0;
      clamp_q <= 1'b0;
      tot_q <= '0;
      it_q <= '0;
      for (int c = 0; c < Channels; c++) corr_q[c] <= '0;
      for (int k = 0; k < 3; k++) sh_q[k] <= '0;
      sensor_out_o <= '0;
      red_corrected_o <= '0;
      green_corrected_o <= '0;
      blue_corrected_o <= '0;
      proximity_corrected_o <= '0;
      ambient_corrected_o <= '0;
      red_share_o <= '0;
      green_share_o <= '0;
      blue_share_o <= '0;
      share_kept_o <= 1'b0;
      share_clamped_o <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (item_take_o && item_i.act == ACT_MEASURE) begin
            it_q <= item_i;
            for (int c = 0; c < Channels; c++)
              corr_q[c] <= $signed({1'b0, raw[c]}) -
                           $signed({1'b0, offs_q[item_i.sensor][c]});
            tot_q <= 19'($signed({1'b0, raw[0]}) - $signed({1'b0, offs_q[item_i.sensor][0]}))
                   + 19'($signed({1'b0, raw[1]}) - $signed({1'b0, offs_q[item_i.sensor][1]}))
                   + 19'($signed({1'b0, raw[2]}) - $signed({1'b0, offs_q[item_i.sensor][2]}));
            k_q <= '0;
            clamp_q <= 1'b0;
            state_q <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          if (tot_q == '0) begin
            for (int k = 0; k < 3; k++) sh_q[k] <= kept_q[it_q.sensor][k];
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (ddone) begin
            if (quo < 0) begin
              sh_q[k_q] <= 8'd0;
              clamp_q <= 1'b1;
            end else if (quo > 26'sd255) begin
              sh_q[k_q] <= 8'd255;
              clamp_q <= 1'b1;
            end else begin
              sh_q[k_q] <= quo[7:0];
            end
            if (k_q == 2'd2) begin
              state_q <= ST_OUT;
            end else begin
              k_q <= k_q + 2'd1;
              state_q <= ST_DIV_START;
            end
          end
        end
        ST_OUT: begin
          if (!valid_o) begin
            valid_o <= 1'b1;
            sensor_out_o <= it_q.sensor;
            red_corrected_o <= corr_q[0];
            green_corrected_o <= corr_q[1];
            blue_corrected_o <= corr_q[2];
            proximity_corrected_o <= corr_q[3];
            ambient_corrected_o <= corr_q[4];
            red_share_o <= sh_q[0];
            green_share_o <= sh_q[1];
            blue_share_o <= sh_q[2];
            share_kept_o <= (tot_q == '0);
            share_clamped_o <= clamp_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (valid_o && !stall_i) valid_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> hdl/color_sensor_offset_normalizer_top.sv
// top level of the color sensor offset normalizer
// A measurement transaction holds the back end while it is taken, while three
// serial divisions of 255*channel by the rgb sum run one after another (each
// a start, 26 quotient bits and a hand-off), and while the result register is
// loaded. With a zero rgb sum the divisions are skipped. Clear and calibration
// transactions are handled in the idle state as they are taken. A two-entry
// queue sits between the front end and the back end, and the result register
// holds a finished result while the next transaction is accepted; a result
// still stalled there when the next one is ready holds the back end until
// it is taken.
`default_nettype none
module color_sensor_offset_normalizer_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire logic [1:0]    action_i,
  input  wire logic [2:0]    sensor_i,
  input  wire logic [15:0]   red_raw_i,
  input  wire logic [15:0]   green_raw_i,
  input  wire logic [15:0]   blue_raw_i,
  input  wire logic [15:0]   proximity_raw_i,
  input  wire logic [15:0]   ambient_raw_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output logic [2:0]         sensor_out_o,
  output logic signed [16:0] red_corrected_o,
  output logic signed [16:0] green_corrected_o,
  output logic signed [16:0] blue_corrected_o,
  output logic signed [16:0] proximity_corrected_o,
  output logic signed [16:0] ambient_corrected_o,
  output logic [7:0]         red_share_o,
  output logic [7:0]         green_share_o,
  output logic [7:0]         blue_share_o,
  output logic               share_kept_o,
  output logic               share_clamped_o
);
  import csn_pkg::*;

  item_t item;
  logic  item_valid, item_take;

  csn_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .action_i, .sensor_i,
    .red_raw_i, .green_raw_i, .blue_raw_i, .proximity_raw_i, .ambient_raw_i,
    .item_o (item), .item_valid_o (item_valid), .item_take_i (item_take)
  );

  csn_back u_back (
    .clk_i, .rst_ni, .item_i (item), .item_valid_i (item_valid),
    .item_take_o (item_take), .valid_o, .stall_i, .sensor_out_o,
    .red_corrected_o, .green_corrected_o, .blue_corrected_o,
    .proximity_corrected_o, .ambient_corrected_o, .red_share_o,
    .green_share_o, .blue_share_o, .share_kept_o, .share_clamped_o
  );

  // a kept result never reports clamping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && share_kept_o |-> !share_clamped_o)
    else $error("kept shares flagged as clamped");

  // result holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(red_share_o))
    else $error("stalled result changed");

  // while the queue is full, the back end only takes an item when one is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> !item_take || item_valid)
    else $error("queue handoff inconsistent");
endmodule
`default_nettype wire

>>> sim/color_sensor_offset_normalizer_top_tb.sv
// testbench for the color sensor offset normalizer top level
`timescale 1ns / 100ps
`default_nettype none
module color_sensor_offset_normalizer_top_tb;
  import csn_pkg::*;

  typedef struct packed {
    logic [2:0]         sensor;
    logic signed [16:0] red_c;
    logic signed [16:0] green_c;
    logic signed [16:0] blue_c;
    logic signed [16:0] prox_c;
    logic signed [16:0] amb_c;
    logic [7:0]         red_sh;
    logic [7:0]         green_sh;
    logic [7:0]         blue_sh;
    logic               kept;
    logic               clamped;
  } color_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic [1:0]         action_i = '0;
  logic [2:0]         sensor_i = '0;
  logic [15:0]        red_raw_i = '0;
  logic [15:0]        green_raw_i = '0;
  logic [15:0]        blue_raw_i = '0;
  logic [15:0]        proximity_raw_i = '0;
  logic [15:0]        ambient_raw_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [2:0]         sensor_out_o;
  logic signed [16:0] red_corrected_o, green_corrected_o, blue_corrected_o;
  logic signed [16:0] proximity_corrected_o, ambient_corrected_o;
  logic [7:0]         red_share_o, green_share_o, blue_share_o;
  logic               share_kept_o, share_clamped_o;

  // predictor state
  logic [31:0]    sum_mdl[SensorCount][Channels];
  logic [15:0]    offset_mdl[SensorCount][Channels];
  int             count_mdl[SensorCount];
  logic [7:0]     shares_mdl[SensorCount][3];
  color_result_t  expected_q[$];
  int             errors = 0;
  int             send_idle_pct = 0;
  int             stall_pct = 0;

  color_sensor_offset_normalizer_top i_dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // share of one channel with clamp
  function automatic logic [7:0] share_calc(longint chan, longint total, ref logic clamp);
    longint q;
    q = (255 * chan) / total;
    if (q < 0) begin
      clamp = 1'b1;
      return 8'd0;
    end
    if (q > 255) begin
      clamp = 1'b1;
      return 8'd255;
    end
    return q[7:0];
  endfunction

  // predict the effect of one transaction
  task automatic predict_sample(logic [1:0] act, logic [2:0] s, logic [15:0] raw[Channels]);
    longint        corr[Channels];
    longint        total;
    color_result_t r;
    logic          clamp;
    if (int'(s) >= SensorCount) return;
    case (act)
      ACT_CLEAR: begin
        for (int c = 0; c < Channels; c++) begin
          sum_mdl[s][c] = 0;
          offset_mdl[s][c] = 0;
        end
        count_mdl[s] = 0;
      end
      ACT_CAL: begin
        for (int c = 0; c < Channels; c++) sum_mdl[s][c] += raw[c];
        count_mdl[s]++;
        if (count_mdl[s] >= CalSamples) begin
          for (int c = 0; c < Channels; c++) begin
            offset_mdl[s][c] = 16'(sum_mdl[s][c] / CalSamples);
            sum_mdl[s][c] = 0;
          end
          count_mdl[s] = 0;
        end
      end
      ACT_MEASURE: begin
        for (int c = 0; c < Channels; c++) corr[c] = longint'(raw[c]) - longint'(offset_mdl[s][c]);
        total = corr[0] + corr[1] + corr[2];
        clamp = 1'b0;
        r.kept = (total == 0);
        if (total != 0) begin
          for (int k = 0; k < 3; k++) shares_mdl[s][k] = share_calc(corr[k], total, clamp);
        end
        r.sensor = s;
        r.red_c = 17'(corr[0]);
        r.green_c = 17'(corr[1]);
        r.blue_c = 17'(corr[2]);
        r.prox_c = 17'(corr[3]);
        r.amb_c = 17'(corr[4]);
        r.red_sh = shares_mdl[s][0];
        r.green_sh = shares_mdl[s][1];
        r.blue_sh = shares_mdl[s][2];
        r.clamped = clamp;
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // send one transaction and predict it
  task automatic send_sample(logic [1:0] act, logic [2:0] s, logic [15:0] r, logic [15:0] g,
                             logic [15:0] b, logic [15:0] p, logic [15:0] a);
    logic [15:0] raw[Channels];
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    raw = '{r, g, b, p, a};
    valid_i <= 1'b1;
    action_i <= act;
    sensor_i <= s;
    red_raw_i <= r;
    green_raw_i <= g;
    blue_raw_i <= b;
    proximity_raw_i <= p;
    ambient_raw_i <= a;
    do @(posedge clk_i); while (stall_o);
    predict_sample(act, s, raw);
  endtask

  // receiver stall
  always @(posedge clk_i) stall_i <= ($urandom_range(99) < stall_pct);

  // result checker
  always @(posedge clk_i) begin
    color_result_t got, want;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{sensor_out_o, red_corrected_o, green_corrected_o, blue_corrected_o,
              proximity_corrected_o, ambient_corrected_o, red_share_o, green_share_o,
              blue_share_o, share_kept_o, share_clamped_o};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          $display("  sensor %0d/%0d corr r %0d/%0d g %0d/%0d b %0d/%0d p %0d/%0d a %0d/%0d",
                   want.sensor, got.sensor, want.red_c, got.red_c, want.green_c, got.green_c,
                   want.blue_c, got.blue_c, want.prox_c, got.prox_c, want.amb_c, got.amb_c);
          $display("  share %0d/%0d %0d/%0d %0d/%0d kept %0b/%0b clamp %0b/%0b",
                   want.red_sh, got.red_sh, want.green_sh, got.green_sh, want.blue_sh,
                   got.blue_sh, want.kept, got.kept, want.clamped, got.clamped);
        end
      end
    end
  end

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // directed: extremes, every action, special cases
  task automatic test_directed();
    send_sample(ACT_MEASURE, 0, 16'hffff, 0, 0, 16'hffff, 16'hffff);
    send_sample(ACT_MEASURE, 0, 0, 0, 0, 0, 0);
    send_sample(ACT_MEASURE, 7, 100, 200, 300, 0, 0);
    for (int i = 0; i < CalSamples; i++)
      send_sample(ACT_CAL, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_sample(ACT_MEASURE, 1, 0, 0, 0, 0, 0);
    send_sample(ACT_MEASURE, 1, 16'hffff, 0, 0, 16'hffff, 0);
    send_sample(ACT_MEASURE, 1, 16'hffff, 16'hffff, 16'hffff, 0, 0);
    for (int i = 0; i < CalSamples; i++) send_sample(ACT_CAL, 2, 1000, 10, 10, 5, 5);
    send_sample(ACT_MEASURE, 2, 2000, 0, 0, 0, 0);
    send_sample(ACT_MEASURE, 2, 500, 20, 20, 0, 0);
    send_sample(ACT_NONE, 2, 1, 2, 3, 4, 5);
    send_sample(ACT_CLEAR, 2, 0, 0, 0, 0, 0);
    send_sample(ACT_MEASURE, 2, 1, 2, 3, 4, 5);
    send_sample(ACT_CAL, 3, 400, 400, 400, 0, 0);
    send_sample(ACT_CLEAR, 3, 0, 0, 0, 0, 0);
    send_sample(ACT_MEASURE, 3, 10, 0, 0, 0, 0);
    wait_drained();
  endtask

  // random: mostly measurements, with calibration samples, clears and unused actions
  task automatic test_random(int n);
    logic [2:0]  s;
    logic [15:0] base;
    for (int i = 0; i < n; i++) begin
      s = 3'($urandom_range(7));
      case ($urandom_range(9))
        0: send_sample(ACT_CLEAR, s, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        1: send_sample(ACT_NONE, s, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        2, 3: begin
          base = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
          send_sample(ACT_CAL, s, 16'(base + $urandom_range(15)),
                      16'(base + $urandom_range(15)), 16'(base + $urandom_range(15)),
                      16'($urandom), 16'($urandom));
        end
        4: send_sample(ACT_MEASURE, s, 16'($urandom_range(30)), 16'($urandom_range(30)),
                       16'($urandom_range(30)), 16'($urandom), 16'($urandom));
        default: begin
          if ($urandom_range(1))
            send_sample(ACT_MEASURE, s, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
          else
            send_sample(ACT_MEASURE, s, 16'($urandom_range(4000)), 16'($urandom_range(4000)),
                        16'($urandom_range(4000)), 16'($urandom), 16'($urandom));
        end
      endcase
      if (i == n / 2) wait_drained();
    end
  endtask

  task automatic run_phase(int idle, int stall, int n);
    send_idle_pct = idle;
    stall_pct = stall;
    test_random(n);
    wait_drained();
  endtask

  initial begin
    for (int s = 0; s < SensorCount; s++) begin
      count_mdl[s] = 0;
      for (int c = 0; c < Channels; c++) begin
        sum_mdl[s][c] = 0;
        offset_mdl[s][c] = 0;
      end
      for (int k = 0; k < 3; k++) shares_mdl[s][k] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    run_phase(0, 0, 500);
    run_phase(81, 0, 350);
    run_phase(0, 81, 350);
    run_phase(35, 35, 450);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // timeout
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
hdl/csn_pkg.sv
hdl/csn_front.sv
hdl/csn_div.sv
hdl/csn_back.sv
hdl/color_sensor_offset_normalizer_top.sv
sim/color_sensor_offset_normalizer_top_tb.sv
